>>> hdl/bsd_pkg.sv
// Shared constants, tables and types for the beam steering delay block.
`default_nettype none

package bsd_pkg;

  // CORDIC iteration count, capped at the size of the arctangent table
  localparam int CORDIC_STAGES = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // CORDIC datapath width (Q2.30 plus growth and sign)
  localparam int CW = 34;

  localparam logic signed [CW-1:0] SIN_GAIN = 34'sd652032874;
  localparam logic [30:0] MDEG_RAD_Q46      = 31'd1228166276;
  localparam logic [30:0] ONE_Q30           = 31'd1073741824;

  // truncated Q2.30 atan(2^-i)
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFD, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  // sideband that travels with every word in the pipeline
  typedef struct packed {
    logic v;
    logic neg;
  } bsd_ctl_t;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_SPEED   = 2'd0,
    CFG_CARRIER = 2'd1,
    CFG_MODE    = 2'd2,
    CFG_SPACING = 2'd3
  } bsd_cfg_idx_t;

endpackage

`default_nettype wire

>>> hdl/beam_steer_delay_top.sv
// Top level: steering angle to inter-element phase and delay, fully pipelined.
//
//  channel | direction | handshake         | word
//  in_     | in        | in_valid/in_stall | steer_angle_mdeg (s20)
//  out_    | out       | out_valid/out_stall | phase_whole_deg (s10), delay_ns (s21)
//  cfg_    | in        | cfg_valid/cfg_ready | cfg_index (2), cfg_data (20)
//
// One word enters per cycle while in_stall is low; most pipeline stages sit in
// the CORDIC chain and the two bit-per-stage dividers (30 and 21 stages).
// Reset (synchronous, rst_n low) clears all valid bits and loads the register
// defaults. A one-word skid behind the output register lets the pipeline take
// one more word while a result waits; in_stall is the skid-full flag.
`default_nettype none

module beam_steer_delay_top import bsd_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic signed [19:0] in_steer_angle_mdeg,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [9:0]       out_phase_whole_deg,
  output logic signed [20:0]      out_delay_ns,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [19:0]        cfg_data
);

  localparam int NQ = 30;   // phase quotient bits
  localparam int ND = 21;   // delay quotient bits
  localparam logic [29:0] RECIP360  = 30'd763549741; // floor(2^38/360)
  localparam logic [20:0] DELAY_MAX = 21'd1048575;

  // ---------------- configuration registers ----------------
  logic [11:0] speed_r;
  logic [19:0] carrier_r;
  logic        mode_r;
  logic [19:0] spacing_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r   <= 12'd343;
      carrier_r <= 20'd39000;
      mode_r    <= 1'b0;
      spacing_r <= 20'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (bsd_cfg_idx_t'(cfg_index))
        CFG_SPEED:   speed_r   <= cfg_data[11:0];
        CFG_CARRIER: carrier_r <= cfg_data;
        CFG_MODE:    mode_r    <= cfg_data[0];
        CFG_SPACING: spacing_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // derived constants, settled long before any word reaches them
  logic [39:0] sc_r;
  logic [48:0] amul_r;    // 360 * spacing * carrier
  logic [31:0] div_d_r;   // 1e6 * speed
  logic [28:0] car360_r;  // 360 * carrier

  always_ff @(posedge clk) begin
    sc_r     <= 40'(spacing_r) * 40'(carrier_r);
    amul_r   <= 49'(sc_r) * 49'd360;
    div_d_r  <= 32'(speed_r) * 32'd1000000;
    car360_r <= 29'(carrier_r) * 29'd360;
  end

  // ---------------- flow control ----------------
  logic sk_v_r;
  logic en;
  assign en       = !sk_v_r;
  assign in_stall = sk_v_r;

  // ---------------- P1: reduce mod 360000 ----------------
  logic signed [21:0] a_s, a_p, a_pp, a_m, a_red;
  assign a_s  = {{2{in_steer_angle_mdeg[19]}}, in_steer_angle_mdeg};
  assign a_p  = a_s + 22'sd360000;
  assign a_pp = a_s + 22'sd720000;
  assign a_m  = a_s - 22'sd360000;

  always_comb begin
    if (a_s < 0) begin
      a_red = (a_p < 0) ? a_pp : a_p;
    end else if (a_s >= 22'sd360000) begin
      a_red = a_m;
    end else begin
      a_red = a_s;
    end
  end

  logic        p1_v_r;
  logic [18:0] p1_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_ang_r <= a_red[18:0];
    end
  end

  // ---------------- P2: fold into the first quadrant ----------------
  logic        f_neg;
  logic [18:0] f_r2, f_r3;
  assign f_neg = p1_ang_r >= 19'd180000;
  assign f_r2  = f_neg ? (p1_ang_r - 19'd180000) : p1_ang_r;
  assign f_r3  = (f_r2 > 19'd90000) ? (19'd180000 - f_r2) : f_r2;

  bsd_ctl_t    p2_ctl_r;
  logic [16:0] p2_ang_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_ctl_r <= '0;
    end else if (en) begin
      p2_ctl_r <= '{v: p1_v_r, neg: f_neg};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p2_ang_r <= f_r3[16:0];
    end
  end

  // ---------------- P3: millidegrees to Q2.30 radians ----------------
  logic [47:0] rad_prod;
  assign rad_prod = 48'(p2_ang_r) * 48'(MDEG_RAD_Q46);

  bsd_ctl_t    p3_ctl_r;
  logic [31:0] p3_z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_ctl_r <= '0;
    end else if (en) begin
      p3_ctl_r <= p2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p3_z_r <= rad_prod[47:16];
    end
  end

  // ---------------- CORDIC sine ----------------
  bsd_ctl_t             cor_ctl;
  logic signed [CW-1:0] cor_y;

  bsd_cordic u_cordic (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .ctl_in  (p3_ctl_r),
    .z_in    (p3_z_r),
    .ctl_out (cor_ctl),
    .y_out   (cor_y)
  );

  // ---------------- K1: clamp sine to [0, 1] ----------------
  logic [30:0] sin_clamp;
  always_comb begin
    if (cor_y[CW-1]) begin
      sin_clamp = '0;
    end else if (cor_y > CW'(ONE_Q30)) begin
      sin_clamp = ONE_Q30;
    end else begin
      sin_clamp = cor_y[30:0];
    end
  end

  bsd_ctl_t    k1_ctl_r;
  logic [30:0] k1_s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k1_ctl_r <= '0;
    end else if (en) begin
      k1_ctl_r <= cor_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k1_s_r <= sin_clamp;
    end
  end

  // ---------------- K2: partial products of A * sin ----------------
  logic [40:0] pp_ll;
  logic [39:0] pp_lh, pp_hl;
  logic [38:0] pp_hh, m0_prod;
  assign pp_ll   = 41'(amul_r[24:0])  * 41'(k1_s_r[15:0]);
  assign pp_lh   = 40'(amul_r[24:0])  * 40'(k1_s_r[30:16]);
  assign pp_hl   = 40'(amul_r[48:25]) * 40'(k1_s_r[15:0]);
  assign pp_hh   = 39'(amul_r[48:25]) * 39'(k1_s_r[30:16]);
  assign m0_prod = 39'(k1_s_r) * 39'd180;   // half-wavelength phase

  bsd_ctl_t    k2_ctl_r;
  logic [40:0] k2_ll_r;
  logic [39:0] k2_lh_r, k2_hl_r;
  logic [38:0] k2_hh_r;
  logic [8:0]  k2_mag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k2_ctl_r <= '0;
    end else if (en) begin
      k2_ctl_r <= k1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k2_ll_r   <= pp_ll;
      k2_lh_r   <= pp_lh;
      k2_hl_r   <= pp_hl;
      k2_hh_r   <= pp_hh;
      k2_mag0_r <= m0_prod[38:30];
    end
  end

  // ---------------- K3: sum and scale by 2^-30 ----------------
  logic [79:0] full_prod;
  assign full_prod = 80'(k2_ll_r) + (80'(k2_lh_r) << 16) + (80'(k2_hl_r) << 25)
                   + (80'(k2_hh_r) << 41);

  bsd_ctl_t    k3_ctl_r;
  logic [48:0] k3_t_r;
  logic [8:0]  k3_mag0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k3_ctl_r <= '0;
    end else if (en) begin
      k3_ctl_r <= k2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      k3_t_r    <= full_prod[78:30];
      k3_mag0_r <= k2_mag0_r;
    end
  end

  // ---------------- phase divider: t / (1e6 * speed) ----------------
  // quotient stays below 2^30, so the top bits start as the remainder
  bsd_ctl_t    q_ctl_r  [1:NQ];
  logic [31:0] q_rem_r  [1:NQ];
  logic [NQ-1:0] q_lo_r [1:NQ];
  logic [8:0]  q_mag0_r [1:NQ];

  for (genvar i = 0; i < NQ; i++) begin : g_qdiv
    bsd_ctl_t      cp;
    logic [31:0]   rp, rn;
    logic [NQ-1:0] lp, ln;
    logic [8:0]    mp;
    logic [32:0]   trial;
    logic          ge;

    if (i == 0) begin : g_head
      assign cp = k3_ctl_r;
      assign rp = {13'b0, k3_t_r[48:30]};
      assign lp = k3_t_r[29:0];
      assign mp = k3_mag0_r;
    end else begin : g_tail
      assign cp = q_ctl_r[i];
      assign rp = q_rem_r[i];
      assign lp = q_lo_r[i];
      assign mp = q_mag0_r[i];
    end

    // one restoring step
    assign trial = {rp, lp[NQ-1]};
    assign ge    = trial >= {1'b0, div_d_r};
    assign rn    = ge ? 32'(trial - {1'b0, div_d_r}) : trial[31:0];
    assign ln    = {lp[NQ-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        q_ctl_r[i+1] <= '0;
      end else if (en) begin
        q_ctl_r[i+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        q_rem_r[i+1]  <= rn;
        q_lo_r[i+1]   <= ln;
        q_mag0_r[i+1] <= mp;
      end
    end
  end

  // ---------------- M1: pick magnitude, reciprocal estimate ----------------
  logic [29:0] mag_sel;
  logic [59:0] recip_prod;
  always_comb begin
    if (!mode_r) begin
      mag_sel = 30'(q_mag0_r[NQ]);
    end else if (speed_r == 12'd0) begin
      mag_sel = '0;
    end else begin
      mag_sel = q_lo_r[NQ];
    end
  end
  assign recip_prod = 60'(mag_sel) * 60'(RECIP360);

  bsd_ctl_t    m1_ctl_r;
  logic [29:0] m1_mag_r;
  logic [21:0] m1_qd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_ctl_r <= '0;
    end else if (en) begin
      m1_ctl_r <= q_ctl_r[NQ];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mag_r <= mag_sel;
      m1_qd_r  <= recip_prod[59:38];
    end
  end

  // ---------------- M2: remainder mod 360 with one correction ----------------
  logic [30:0] qd360, mrem;
  logic [9:0]  mrem10;
  logic [8:0]  mag9;
  assign qd360  = 31'(m1_qd_r) * 31'd360;
  assign mrem   = 31'(m1_mag_r) - qd360;
  assign mrem10 = mrem[9:0];
  assign mag9   = (mrem10 >= 10'd360) ? 9'(mrem10 - 10'd360) : mrem10[8:0];

  bsd_ctl_t   m2_ctl_r;
  logic [8:0] m2_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_ctl_r <= '0;
    end else if (en) begin
      m2_ctl_r <= m1_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m2_mag_r <= mag9;
    end
  end

  // ---------------- D1: delay numerator, phase * 1e9 ----------------
  logic [38:0] num_prod;
  assign num_prod = 39'(m2_mag_r) * 39'd1000000000;

  bsd_ctl_t    d1_ctl_r;
  logic [38:0] d1_n_r;
  logic [8:0]  d1_mag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_ctl_r <= '0;
    end else if (en) begin
      d1_ctl_r <= m2_ctl_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_n_r   <= num_prod;
      d1_mag_r <= m2_mag_r;
    end
  end

  // ---------------- delay divider: n / (360 * carrier) ----------------
  // a quotient of 2^21 or more saturates, flagged up front
  logic d_ovf0;
  assign d_ovf0 = 29'(d1_n_r[38:21]) >= car360_r;

  bsd_ctl_t      d_ctl_r [1:ND];
  logic [28:0]   d_rem_r [1:ND];
  logic [ND-1:0] d_lo_r  [1:ND];
  logic [8:0]    d_mag_r [1:ND];
  logic          d_ovf_r [1:ND];

  for (genvar i = 0; i < ND; i++) begin : g_ddiv
    bsd_ctl_t      cp;
    logic [28:0]   rp, rn;
    logic [ND-1:0] lp, ln;
    logic [8:0]    mp;
    logic          op;
    logic [29:0]   trial;
    logic          ge;

    if (i == 0) begin : g_head
      assign cp = d1_ctl_r;
      assign rp = 29'(d1_n_r[38:21]);
      assign lp = d1_n_r[20:0];
      assign mp = d1_mag_r;
      assign op = d_ovf0;
    end else begin : g_tail
      assign cp = d_ctl_r[i];
      assign rp = d_rem_r[i];
      assign lp = d_lo_r[i];
      assign mp = d_mag_r[i];
      assign op = d_ovf_r[i];
    end

    assign trial = {rp, lp[ND-1]};
    assign ge    = trial >= {1'b0, car360_r};
    assign rn    = ge ? 29'(trial - {1'b0, car360_r}) : trial[28:0];
    assign ln    = {lp[ND-2:0], ge};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        d_ctl_r[i+1] <= '0;
      end else if (en) begin
        d_ctl_r[i+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        d_rem_r[i+1] <= rn;
        d_lo_r[i+1]  <= ln;
        d_mag_r[i+1] <= mp;
        d_ovf_r[i+1] <= op;
      end
    end
  end

  // ---------------- F: saturate and apply sign ----------------
  logic [20:0]        dly_mag;
  logic signed [20:0] fin_delay;
  logic signed [9:0]  fin_phase;
  logic               fin_neg;

  assign fin_neg = d_ctl_r[ND].neg;

  always_comb begin
    if (carrier_r == 20'd0) begin
      dly_mag = '0;
    end else if (d_ovf_r[ND] || (d_lo_r[ND] > DELAY_MAX)) begin
      dly_mag = DELAY_MAX;
    end else begin
      dly_mag = d_lo_r[ND];
    end
  end

  assign fin_delay = fin_neg ? -$signed(dly_mag) : $signed(dly_mag);
  assign fin_phase = fin_neg ? -$signed({1'b0, d_mag_r[ND]}) : $signed({1'b0, d_mag_r[ND]});

  logic               fin_v_r;
  logic signed [9:0]  fin_phase_r;
  logic signed [20:0] fin_delay_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (en) begin
      fin_v_r <= d_ctl_r[ND].v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fin_phase_r <= fin_phase;
      fin_delay_r <= fin_delay;
    end
  end

  // ---------------- output register and skid ----------------
  logic               out_valid_r;
  logic signed [9:0]  out_phase_r, sk_phase_r;
  logic signed [20:0] out_delay_r, sk_delay_r;
  logic               out_hold;

  assign out_hold = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sk_v_r      <= 1'b0;
    end else if (out_hold) begin
      if (en && fin_v_r) begin
        sk_v_r <= 1'b1;
      end
    end else if (sk_v_r) begin
      out_valid_r <= 1'b1;
      sk_v_r      <= 1'b0;
    end else begin
      out_valid_r <= fin_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_hold) begin
      if (en && fin_v_r) begin
        sk_phase_r <= fin_phase_r;
        sk_delay_r <= fin_delay_r;
      end
    end else if (sk_v_r) begin
      out_phase_r <= sk_phase_r;
      out_delay_r <= sk_delay_r;
    end else begin
      out_phase_r <= fin_phase_r;
      out_delay_r <= fin_delay_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_phase_whole_deg = out_phase_r;
  assign out_delay_ns        = out_delay_r;

  // ---------------- checks ----------------
  // skid only fills behind a stalled output word
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(sk_v_r) |-> $past(out_valid_r && out_stall))
    else $error("skid filled without a stalled output");

  // a taken output word drains a full skid
  a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_stall && sk_v_r) |=> (!sk_v_r && out_valid_r))
    else $error("skid did not drain");

  // phase stays within one turn
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_phase_r >= -10'sd359 && out_phase_r <= 10'sd359))
    else $error("phase out of range");

  // a non-negative phase never gives a negative delay
  a_sign_match: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_phase_r[9]) |-> !out_delay_r[20])
    else $error("delay sign disagrees with phase");

endmodule

`default_nettype wire

>>> hdl/bsd_cordic.sv
// Pipelined rotation-mode CORDIC, one iteration per register stage.
`default_nettype none

module bsd_cordic import bsd_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire bsd_ctl_t          ctl_in,
  input  wire logic [31:0]       z_in,
  output bsd_ctl_t               ctl_out,
  output logic signed [CW-1:0]   y_out
);

  bsd_ctl_t              ctl_r [1:CORDIC_N];
  logic signed [CW-1:0]  x_r   [1:CORDIC_N];
  logic signed [CW-1:0]  y_r   [1:CORDIC_N];
  logic signed [CW-1:0]  z_r   [1:CORDIC_N];

  for (genvar i = 0; i < CORDIC_N; i++) begin : g_stage
    bsd_ctl_t             cp;
    logic signed [CW-1:0] xp, yp, zp, dx, dy, at, xn, yn, zn;

    // stage source: start vector or previous stage
    if (i == 0) begin : g_head
      assign cp = ctl_in;
      assign xp = SIN_GAIN;
      assign yp = '0;
      assign zp = {2'b00, z_in};
    end else begin : g_tail
      assign cp = ctl_r[i];
      assign xp = x_r[i];
      assign yp = y_r[i];
      assign zp = z_r[i];
    end

    // floor shifts and the step angle
    assign dx = yp >>> i;
    assign dy = xp >>> i;
    assign at = {2'b00, ATAN_Q30[i]};

    // rotate toward zero residual angle; z >= 0 counts as positive
    always_comb begin
      if (!zp[CW-1]) begin
        xn = xp - dx;
        yn = yp + dy;
        zn = zp - at;
      end else begin
        xn = xp + dx;
        yn = yp - dy;
        zn = zp + at;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        ctl_r[i+1] <= '0;
      end else if (en) begin
        ctl_r[i+1] <= cp;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[i+1] <= xn;
        y_r[i+1] <= yn;
        z_r[i+1] <= zn;
      end
    end
  end

  assign ctl_out = ctl_r[CORDIC_N];
  assign y_out   = y_r[CORDIC_N];

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for beam_steer_delay_top: scoreboard-checked random and directed steering angles.
`default_nettype none

module tb;
  import bsd_pkg::*;

  // one expected result word
  typedef struct {
    logic signed [9:0]  phase;
    logic signed [20:0] delay;
  } steer_result_t;

  // predicts phase/delay from the angle and tracks outstanding results
  class steer_scoreboard;
    longint unsigned speed, carrier, mode, spacing;
    steer_result_t   pending[$];
    int              errors;

    function new();
      speed = 343; carrier = 39000; mode = 0; spacing = 0; errors = 0;
    endfunction

    function void write_reg(bsd_cfg_idx_t idx, logic [19:0] val);
      case (idx)
        CFG_SPEED:   speed   = 64'(val[11:0]);
        CFG_CARRIER: carrier = 64'(val);
        CFG_MODE:    mode    = 64'(val[0]);
        CFG_SPACING: spacing = 64'(val);
        default: ;
      endcase
    endfunction

    // Q2.30 sine of r millidegrees, r in [0,90000]
    function longint sine_q30(longint r);
      longint x, y, z, dx, dy;
      x = longint'(SIN_GAIN); y = 0;
      z = (r * longint'(MDEG_RAD_Q46)) >>> 16;
      for (int i = 0; i < CORDIC_N; i++) begin
        dx = y >>> i; dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= longint'(ATAN_Q30[i]);
        end else begin
          x += dx; y -= dy; z += longint'(ATAN_Q30[i]);
        end
      end
      if (y < 0) y = 0;
      if (y > longint'(ONE_Q30)) y = longint'(ONE_Q30);
      return y;
    endfunction

    function void note_angle(logic signed [19:0] ang);
      longint a, r;
      bit neg;
      longint unsigned s, mag, big_a, u, v, t, dl;
      steer_result_t res;
      a = longint'(ang);
      r = a % 360000;
      if (r < 0) r += 360000;
      neg = 0;
      if (r >= 180000) begin
        neg = 1; r -= 180000;
      end
      if (r > 90000) r = 180000 - r;
      s = sine_q30(r);
      if (mode == 0) begin
        mag = (180 * s) >> 30;
      end else if (speed == 0) begin
        mag = 0;
      end else begin
        big_a = 360 * spacing * carrier;
        u = big_a * (s >> 15);
        v = big_a * (s & 64'h7FFF);
        t = (u + (v >> 15)) >> 15;
        mag = t / (1000000 * speed);
      end
      mag = mag % 360;
      res.phase = 10'(neg ? -longint'(mag) : longint'(mag));
      if (carrier == 0) begin
        res.delay = 0;
      end else begin
        dl = (mag * 1000000000) / (360 * carrier);
        if (dl > 1048575) dl = 1048575;
        res.delay = 21'(neg ? -longint'(dl) : longint'(dl));
      end
      pending.push_back(res);
    endfunction

    function void check_result(logic signed [9:0] phase, logic signed [20:0] delay);
      steer_result_t e;
      if (pending.size() == 0) begin
        $error("unexpected result word: phase %0d delay %0d", phase, delay);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (phase !== e.phase) begin
        $error("phase_whole_deg: expected %0d, got %0d", e.phase, phase);
        errors++;
      end
      if (delay !== e.delay) begin
        $error("delay_ns: expected %0d, got %0d", e.delay, delay);
        errors++;
      end
    endfunction
  endclass

  logic               clk, rst_n;
  logic               in_valid, in_stall;
  logic signed [19:0] in_steer_angle_mdeg;
  logic               out_valid, out_stall;
  logic signed [9:0]  out_phase_whole_deg;
  logic signed [20:0] out_delay_ns;
  logic               cfg_valid, cfg_ready;
  logic [1:0]         cfg_index;
  logic [19:0]        cfg_data;

  steer_scoreboard sb;
  bit              calm;      // phase without idling on either side
  int              quiet_cycles;

  beam_steer_delay_top u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_steer_angle_mdeg,
    .out_valid, .out_stall, .out_phase_whole_deg, .out_delay_ns,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  initial sb = new();

  // result check and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_phase_whole_deg, out_delay_ns);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready) ||
        !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 3000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver stalls at random before each word
  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      n = calm ? 0 : $urandom_range(0, 18);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_angle(logic signed [19:0] ang);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 18);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_steer_angle_mdeg <= ang;
    do @(posedge clk); while (in_stall);
    sb.note_angle(ang);
  endtask

  // one register write; the caller drops cfg_valid after the last one
  task automatic write_reg(bsd_cfg_idx_t idx, logic [19:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  // drain the pipeline before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic load_config(logic [19:0] spd, logic [19:0] car, logic [19:0] md,
                             logic [19:0] sp);
    wait_idle();
    write_reg(CFG_SPEED, spd);
    write_reg(CFG_CARRIER, car);
    write_reg(CFG_MODE, md);
    write_reg(CFG_SPACING, sp);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_angles(int n);
    logic signed [19:0] ang;
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(0, 3))
        0:       ang = 20'($urandom);
        1:       ang = 20'($signed($urandom_range(0, 720000)) - 360000);
        2:       ang = 20'($signed($urandom_range(0, 180000)) - 90000);
        default: ang = 20'($signed($urandom_range(0, 10)) * 45000 - 225000 +
                           $signed($urandom_range(0, 2)) - 1);
      endcase
      send_angle(ang);
    end
  endtask

  logic signed [19:0] corner_angles[$] = '{
    0, 1, -1, 45000, 90000, -90000, 89999, 90001, 135000, 180000, -180000,
    179999, 270000, -270000, 359999, 360000, -360000, 360001, 524287, -524288
  };

  initial begin
    in_valid            <= 1'b0;
    in_steer_angle_mdeg <= '0;
    cfg_valid           <= 1'b0;
    cfg_index           <= CFG_SPEED;
    cfg_data            <= '0;
    calm                = 1'b0;
    rst_n               <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults: half-wavelength spacing
    foreach (corner_angles[k]) send_angle(corner_angles[k]);
    random_angles(100);

    // explicit spacing, zero speed
    load_config(0, 39000, 1, 4300);
    send_angle(90000); send_angle(-45000);
    // zero carrier
    load_config(343, 0, 1, 4300);
    send_angle(90000); send_angle(-90000);
    // carrier below range: delay saturates
    load_config(343, 1, 0, 0);
    send_angle(90000); send_angle(-30000);
    random_angles(30);

    // maxima of every register
    calm = 1'b1;
    load_config(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF);
    random_angles(100);
    calm = 1'b0;

    // random settings, mostly in range, one in four full width
    for (int p = 0; p < 6; p++) begin
      if ($urandom_range(0, 3) == 0)
        load_config(20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom));
      else
        load_config(20'($urandom_range(100, 4000)), 20'($urandom_range(1000, 1000000)),
                    20'($urandom_range(0, 1)), 20'($urandom_range(0, 30000)));
      calm = (p == 2);
      random_angles(100);
    end
    calm = 1'b0;

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
